[src/otfss_pkg.sv]
// ----------------------------------------------------------------------------
// otfss_pkg: shared types and constants of the fan speed selector
// Register codes, classification record, deviation bands and duty table.
// ----------------------------------------------------------------------------
package otfss_pkg;

  // field widths
  localparam int TEMP_W    = 11;
  localparam int HUM_W     = 10;
  localparam int OCC_W     = 7;
  localparam int DEV_W     = 12;
  localparam int DUTY_W    = 8;
  localparam int LEVEL_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // occupancy limits
  localparam logic [OCC_W-1:0] OCC_CLAMP     = 7'd100;
  localparam logic [OCC_W-1:0] OCC_THRESHOLD = 7'd15;

  // deviation bands in tenths, with hysteresis already taken off
  localparam logic signed [DEV_W-1:0] BAND_HIGH     = 12'sd25;
  localparam logic signed [DEV_W-1:0] BAND_HIGH_HYS = 12'sd20;
  localparam logic signed [DEV_W-1:0] BAND_MED      = 12'sd10;
  localparam logic signed [DEV_W-1:0] BAND_MED_HYS  = 12'sd5;

  // speed levels
  localparam logic [LEVEL_W-1:0] LVL_OFF  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MED  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd3;

  // PWM duties
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_LOW  = 8'd85;
  localparam logic [DUTY_W-1:0] DUTY_MED  = 8'd170;
  localparam logic [DUTY_W-1:0] DUTY_HIGH = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIER_MID_OCC  = 3'd0,
    REG_TIER_HIGH_OCC = 3'd1,
    REG_TEMP_LOW      = 3'd2,
    REG_TEMP_MID      = 3'd3,
    REG_TEMP_HIGH     = 3'd4,
    REG_HUM_LOW       = 3'd5,
    REG_HUM_MID       = 3'd6,
    REG_HUM_HIGH      = 3'd7
  } reg_idx_t;

  // register file contents
  typedef struct packed {
    logic [OCC_W-1:0]  tier_mid_occ;
    logic [OCC_W-1:0]  tier_high_occ;
    logic [TEMP_W-1:0] temp_low;
    logic [TEMP_W-1:0] temp_mid;
    logic [TEMP_W-1:0] temp_high;
    logic [HUM_W-1:0]  hum_low;
    logic [HUM_W-1:0]  hum_mid;
    logic [HUM_W-1:0]  hum_high;
  } cfg_t;

  // classified sample: band compares done, hysteresis choice left to the back
  typedef struct packed {
    logic off;
    logic ge_high;
    logic ge_high_hys;
    logic ge_med;
    logic ge_med_hys;
  } cls_t;

  function automatic logic [DUTY_W-1:0] duty_of_level(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    case (lvl)
      LVL_LOW:  d = DUTY_LOW;
      LVL_MED:  d = DUTY_MED;
      LVL_HIGH: d = DUTY_HIGH;
      default:  d = DUTY_OFF;
    endcase
    return d;
  endfunction

endpackage

[src/otfss_regs.sv]
// ----------------------------------------------------------------------------
// otfss_regs: configuration register file
// Eight tier limits and targets, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
module otfss_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [otfss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [otfss_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  output otfss_pkg::cfg_t                    cfg_o
);

  otfss_pkg::cfg_t regs_r;

  // writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg_o     = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.tier_mid_occ  <= 7'd40;
      regs_r.tier_high_occ <= 7'd70;
      regs_r.temp_low      <= 11'd270;
      regs_r.temp_mid      <= 11'd250;
      regs_r.temp_high     <= 11'd230;
      regs_r.hum_low       <= 10'd650;
      regs_r.hum_mid       <= 10'd600;
      regs_r.hum_high      <= 10'd550;
    end else if (cfg_valid && cfg_ready) begin
      case (otfss_pkg::reg_idx_t'(cfg_index))
        otfss_pkg::REG_TIER_MID_OCC:  regs_r.tier_mid_occ  <= cfg_wdata[otfss_pkg::OCC_W-1:0];
        otfss_pkg::REG_TIER_HIGH_OCC: regs_r.tier_high_occ <= cfg_wdata[otfss_pkg::OCC_W-1:0];
        otfss_pkg::REG_TEMP_LOW:      regs_r.temp_low      <= cfg_wdata[otfss_pkg::TEMP_W-1:0];
        otfss_pkg::REG_TEMP_MID:      regs_r.temp_mid      <= cfg_wdata[otfss_pkg::TEMP_W-1:0];
        otfss_pkg::REG_TEMP_HIGH:     regs_r.temp_high     <= cfg_wdata[otfss_pkg::TEMP_W-1:0];
        otfss_pkg::REG_HUM_LOW:       regs_r.hum_low       <= cfg_wdata[otfss_pkg::HUM_W-1:0];
        otfss_pkg::REG_HUM_MID:       regs_r.hum_mid       <= cfg_wdata[otfss_pkg::HUM_W-1:0];
        otfss_pkg::REG_HUM_HIGH:      regs_r.hum_high      <= cfg_wdata[otfss_pkg::HUM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/otfss_front.sv]
// ----------------------------------------------------------------------------
// otfss_front: sample classifier
// Clamps occupancy, picks the comfort tier, forms both deviations and
// compares them against every band the back might need.
// ----------------------------------------------------------------------------
module otfss_front (
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [otfss_pkg::TEMP_W-1:0]      in_temperature,
  input  logic [otfss_pkg::HUM_W-1:0]              in_humidity,
  input  logic [otfss_pkg::OCC_W-1:0]              in_occupancy,
  input  logic                                     in_sensor_fail,
  input  otfss_pkg::cfg_t                          cfg_i,
  input  logic                                     q_full,
  output logic                                     q_push,
  output otfss_pkg::cls_t                          q_wdata
);

  logic [otfss_pkg::OCC_W-1:0]         occ_c;
  logic [otfss_pkg::TEMP_W-1:0]        temp_tgt;
  logic [otfss_pkg::HUM_W-1:0]         hum_tgt;
  logic signed [otfss_pkg::DEV_W-1:0]  t_dev;
  logic signed [otfss_pkg::DEV_W-1:0]  h_dev;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // occupancy clamp and tier choice
  always_comb begin
    occ_c = (in_occupancy > otfss_pkg::OCC_CLAMP) ? otfss_pkg::OCC_CLAMP : in_occupancy;
    if (occ_c >= cfg_i.tier_high_occ) begin
      temp_tgt = cfg_i.temp_high;
      hum_tgt  = cfg_i.hum_high;
    end else if (occ_c >= cfg_i.tier_mid_occ) begin
      temp_tgt = cfg_i.temp_mid;
      hum_tgt  = cfg_i.hum_mid;
    end else begin
      temp_tgt = cfg_i.temp_low;
      hum_tgt  = cfg_i.hum_low;
    end
  end

  // deviations, one bit wider than the temperature operands and two wider than the humidity ones, so they never wrap
  assign t_dev = $signed({in_temperature[otfss_pkg::TEMP_W-1], in_temperature})
               - $signed({temp_tgt[otfss_pkg::TEMP_W-1], temp_tgt});
  assign h_dev = $signed({2'b00, in_humidity}) - $signed({2'b00, hum_tgt});

  // band compares
  always_comb begin
    q_wdata.off         = in_sensor_fail || (occ_c < otfss_pkg::OCC_THRESHOLD);
    q_wdata.ge_high     = (t_dev >= otfss_pkg::BAND_HIGH)     || (h_dev >= otfss_pkg::BAND_HIGH);
    q_wdata.ge_high_hys = (t_dev >= otfss_pkg::BAND_HIGH_HYS) ||
                          (h_dev >= otfss_pkg::BAND_HIGH_HYS);
    q_wdata.ge_med      = (t_dev >= otfss_pkg::BAND_MED)      || (h_dev >= otfss_pkg::BAND_MED);
    q_wdata.ge_med_hys  = (t_dev >= otfss_pkg::BAND_MED_HYS)  || (h_dev >= otfss_pkg::BAND_MED_HYS);
  end

endmodule

[src/otfss_queue.sv]
// ----------------------------------------------------------------------------
// otfss_queue: short queue of classified samples
// Circular buffer between front and back; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module otfss_queue #(
  parameter int DEPTH = otfss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  otfss_pkg::cls_t  wdata,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output otfss_pkg::cls_t  rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  otfss_pkg::cls_t  mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

[src/otfss_back.sv]
// ----------------------------------------------------------------------------
// otfss_back: level decision and result register
// Applies hysteresis from the last level, raises the kick flag and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module otfss_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  otfss_pkg::cls_t                     q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [otfss_pkg::DUTY_W-1:0]        out_fan_duty,
  output logic [otfss_pkg::LEVEL_W-1:0]       out_speed_level,
  output logic                                out_kick_pulse
);

  logic                               out_valid_r, out_valid_nxt;
  logic [otfss_pkg::DUTY_W-1:0]       duty_r;
  logic [otfss_pkg::LEVEL_W-1:0]      level_r;
  logic                               kick_r;
  logic [otfss_pkg::LEVEL_W-1:0]      last_r, last_nxt;
  logic [otfss_pkg::LEVEL_W-1:0]      level_nxt;
  logic                               band_high, band_med;

  // take the next request when the result register is free or draining
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // hysteresis: lower bands once the fan already runs that fast
  always_comb begin
    band_high = (last_r == otfss_pkg::LVL_HIGH) ? q_rdata.ge_high_hys : q_rdata.ge_high;
    band_med  = (last_r >= otfss_pkg::LVL_MED)  ? q_rdata.ge_med_hys  : q_rdata.ge_med;
    if (q_rdata.off) begin
      level_nxt = otfss_pkg::LVL_OFF;
    end else if (band_high) begin
      level_nxt = otfss_pkg::LVL_HIGH;
    end else if (band_med) begin
      level_nxt = otfss_pkg::LVL_MED;
    end else begin
      level_nxt = otfss_pkg::LVL_LOW;
    end
    last_nxt      = q_pop ? level_nxt : last_r;
    out_valid_nxt = q_pop || (out_valid_r && out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= otfss_pkg::LVL_OFF;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      level_r <= level_nxt;
      duty_r  <= otfss_pkg::duty_of_level(level_nxt);
      kick_r  <= (last_r == otfss_pkg::LVL_OFF) && (level_nxt != otfss_pkg::LVL_OFF);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fan_duty    = duty_r;
  assign out_speed_level = level_r;
  assign out_kick_pulse  = kick_r;

  // checks
  a_kick_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kick_r |-> level_r != otfss_pkg::LVL_OFF)
    else $error("kick raised with fan off");

  a_duty_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> duty_r == otfss_pkg::duty_of_level(level_r))
    else $error("duty does not match level");

  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> last_r == level_r)
    else $error("last level not updated from popped request");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !q_pop)
    else $error("held result overwritten");

endmodule

[src/occupancy_tiered_fan_speed_selector.sv]
// ----------------------------------------------------------------------------
// occupancy_tiered_fan_speed_selector: top level
// Chooses a fan speed level and PWM duty for each sensor sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one sensor sample per
//   request: temperature and humidity in tenths, occupancy percent and a
//   sensor-fail flag. Output channel (out_valid / out_stall) returns one
//   result per sample: duty, speed level and kick flag, in sample order.
//   Configuration channel (cfg_valid / cfg_ready) writes one tier register
//   per request; cfg_ready is always high. Write only while idle.
//   An accepted sample is written into the queue and then popped into the
//   result register. Throughput: one sample per cycle while out_stall is
//   low; the last-level register in the back is updated on every pop.
//   The front classifies into a QUEUE_DEPTH entry queue; in_stall rises
//   only when that queue is full, i.e. when out_stall has held the result
//   register and the queue has filled behind it.
//   Reset (rst_n low, synchronous) empties the queue, drops out_valid,
//   sets the last level to off and loads the register defaults.
// ----------------------------------------------------------------------------
module occupancy_tiered_fan_speed_selector #(
  parameter int QUEUE_DEPTH = otfss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [otfss_pkg::TEMP_W-1:0]   in_temperature,
  input  logic [otfss_pkg::HUM_W-1:0]           in_humidity,
  input  logic [otfss_pkg::OCC_W-1:0]           in_occupancy,
  input  logic                                  in_sensor_fail,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [otfss_pkg::DUTY_W-1:0]          out_fan_duty,
  output logic [otfss_pkg::LEVEL_W-1:0]         out_speed_level,
  output logic                                  out_kick_pulse,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [otfss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [otfss_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  otfss_pkg::cfg_t  cfg;
  otfss_pkg::cls_t  q_wdata, q_rdata;
  logic             q_push, q_full, q_pop, q_valid;

  // register file
  otfss_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // classifier
  otfss_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_temperature (in_temperature),
    .in_humidity    (in_humidity),
    .in_occupancy   (in_occupancy),
    .in_sensor_fail (in_sensor_fail),
    .cfg_i          (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // queue between front and back
  otfss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  // level decision and result register
  otfss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fan_duty    (out_fan_duty),
    .out_speed_level (out_speed_level),
    .out_kick_pulse  (out_kick_pulse)
  );

endmodule
